FILE: hw/rtl/mtep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int TRACK_COUNT_DEF = 16;

   localparam logic [3:0] PH_DELTA    = 4'd0;
   localparam logic [3:0] PH_STATUS   = 4'd1;
   localparam logic [3:0] PH_DATA1    = 4'd2;
   localparam logic [3:0] PH_DATA2    = 4'd3;
   localparam logic [3:0] PH_SYSLEN   = 4'd4;
   localparam logic [3:0] PH_SYSDATA  = 4'd5;
   localparam logic [3:0] PH_METATYPE = 4'd6;
   localparam logic [3:0] PH_METALEN  = 4'd7;
   localparam logic [3:0] PH_METADATA = 4'd8;
   localparam logic [3:0] PH_HOLD     = 4'hE;
   localparam logic [3:0] PH_FAIL     = 4'hF;

   localparam logic [2:0] KIND_DUE   = 3'd0;
   localparam logic [2:0] KIND_SHORT = 3'd1;
   localparam logic [2:0] KIND_SYSEX = 3'd2;
   localparam logic [2:0] KIND_TICK  = 3'd3;
   localparam logic [2:0] KIND_SEQ   = 3'd4;
   localparam logic [2:0] KIND_ERR   = 3'd5;

   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_SEQ   = 8'h00;
   localparam logic [14:0] TEMPO_SCALE = 15'd25000;

   localparam logic [0:0] CSR_TPQ = 1'd0;

   typedef struct packed {
      logic [3:0]  phase;
      logic [7:0]  rstat;
      logic [6:0]  held;
      logic [27:0] acc;
      logic [2:0]  cnt;
      logic [27:0] remain;
      logic [7:0]  mtype;
      logic [23:0] payload;
      logic [31:0] due;
   } track_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  track;
      logic [7:0]  status;
      logic [6:0]  d1;
      logic [6:0]  d2;
      logic [31:0] value;
      logic        last;
   } rsp_type;

   function automatic logic [1:0] data_count(input logic [3:0] hi);
      logic [1:0] r;
      unique case (hi)
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: r = 2'd2;
         4'hC, 4'hD:                   r = 2'd1;
         default:                      r = 2'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mtep_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtep_divider
// Restoring divider, one quotient bit per cycle, 32 by 24 bits.
// ----------------------------------------------------------------------------
module mtep_divider import mtep_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [23:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] q_ff, q_in;
   logic [24:0] r_ff, r_in;
   logic [23:0] d_ff, d_in;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [24:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff; busy_in = busy_ff;
      trial = {r_ff[23:0], q_ff[31]};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = busy_ff && (n_ff == 6'd1);
   assign quotient = q_in;
endmodule
`default_nettype wire

FILE: hw/rtl/midi_track_event_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Per-track parser of MIDI file track bytes with a shared divider for tempo.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// req      in   req_valid/stall    track_id, data_byte, restart
// rsp      out  rsp_valid/stall    kind .. last
// csr      in   APB                ticks_per_quarter
// A byte passes through accept, state read, then parse and write back.
// A byte that gives a word holds off the next accept until the word is
// taken, longer while rsp_stall is high. A tempo event waits on the divider.
// Per-track state sits in a small memory; a clear pass over all TRACK_COUNT
// entries runs after reset. req_stall is high while busy or rsp is full.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; #(
   parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_track_id,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_restart,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [3:0]       rsp_out_track,
   output logic [7:0]       rsp_status_out,
   output logic [6:0]       rsp_first_data,
   output logic [6:0]       rsp_second_data,
   output logic [31:0]      rsp_value,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int IW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
   localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2,
                          S_EXEC = 3'd3, S_DIV = 3'd4;

   track_type mem [TRACK_COUNT];
   track_type rd_ff, ts;
   logic [2:0]  st_ff, st_in;
   logic [IW-1:0] clr_ff, idx_ff;
   logic [3:0]  tid_ff;
   logic [7:0]  byte_ff;
   logic        rst_ff;
   logic [15:0] tpq_ff;
   rsp_type     out_ff, res;
   logic        ov_ff, emit;
   logic        we;
   track_type   wd;
   logic [IW-1:0] wa;
   logic        dstart, ddone, need_div;
   logic [31:0] dquot, dividend;
   logic [23:0] tempo;
   logic        csr_wr;
   logic [31:0] dividend_ff;
   rsp_type     pend_ff, div_res;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == CSR_TPQ) ? {16'd0, tpq_ff} : 32'd0;
   assign req_stall = (st_ff != S_IDLE) || ov_ff;

   always_ff @(posedge clock) begin
      if (reset) tpq_ff <= 16'd1;
      else if (csr_wr && paddr[2] == CSR_TPQ) tpq_ff <= pwdata[15:0];
   end

   // parse one byte on state ts (combinational)
   always_comb begin
      track_type t;
      logic [7:0] b, s;
      logic [3:0] ph;
      logic [27:0] acc;
      logic [2:0] c;
      logic fin_meta, vbad, vdone;
      logic [23:0] p;
      t = ts; b = byte_ff; emit = 1'b0; need_div = 1'b0; fin_meta = 1'b0; s = '0;
      res = '0; res.track = tid_ff; p = '0;
      acc = {t.acc[20:0], b[6:0]}; c = t.cnt + 3'd1;
      vbad = b[7] && (c >= 3'd4); vdone = !b[7];
      ph = t.phase;
      if (ph == PH_STATUS) begin
         s = b[7] ? b : t.rstat;
         if (b[7]) t.rstat = b;
         t.acc = '0; t.cnt = '0;
         priority if (s < 8'h80 || (s >= 8'hF8 && s != 8'hFF)) ph = PH_FAIL;
         else if (s < 8'hF0) ph = PH_DATA1;
         else if (s <= 8'hF7) ph = PH_SYSLEN;
         else ph = PH_METATYPE;
         if (ph == PH_FAIL) begin
            t.phase = PH_DELTA; t.remain = '0; emit = 1'b1; res.kind = KIND_ERR;
         end else begin
            t.phase = ph;
            if (b[7]) ph = PH_HOLD;
            acc = {21'd0, b[6:0]}; c = 3'd1;
            vbad = b[7]; vdone = !b[7];
         end
      end
      unique case (ph)
         PH_DATA1: begin
            if (data_count(t.rstat[7:4]) == 2'd1) begin
               t.phase = PH_DELTA; emit = 1'b1; res.kind = KIND_SHORT;
               res.status = t.rstat; res.d1 = b[6:0];
            end else begin
               t.held = b[6:0]; t.phase = PH_DATA2;
            end
         end
         PH_DATA2: begin
            t.phase = PH_DELTA; emit = 1'b1; res.kind = KIND_SHORT;
            res.status = t.rstat; res.d1 = t.held; res.d2 = b[6:0];
         end
         PH_SYSLEN, PH_METALEN: begin
            t.acc = acc; t.cnt = c;
            if (vbad) begin
               t.phase = PH_DELTA; t.acc = '0; t.cnt = '0; t.remain = '0;
               emit = 1'b1; res.kind = KIND_ERR;
            end else if (vdone) begin
               t.cnt = '0; t.remain = acc; t.acc = '0;
               if (ph == PH_METALEN) begin
                  t.payload = '0;
                  if (acc == '0) fin_meta = 1'b1;
                  else t.phase = PH_METADATA;
               end else t.phase = (acc == '0) ? PH_DELTA : PH_SYSDATA;
            end
         end
         PH_SYSDATA: begin
            t.remain = t.remain - 28'd1; emit = 1'b1; res.kind = KIND_SYSEX;
            res.value = {24'd0, b};
            if (t.remain == '0) begin
               t.phase = PH_DELTA; res.last = 1'b1;
            end
         end
         PH_METATYPE: begin
            t.mtype = b; t.acc = '0; t.cnt = '0; t.phase = PH_METALEN;
         end
         PH_METADATA: begin
            if (t.cnt < 3'd3) begin
               t.payload = {t.payload[15:0], b}; t.cnt = t.cnt + 3'd1;
            end
            t.remain = t.remain - 28'd1;
            if (t.remain == '0) fin_meta = 1'b1;
         end
         PH_DELTA: begin
            t.phase = PH_DELTA; t.acc = acc; t.cnt = c;
            if (vbad) begin
               t.acc = '0; t.cnt = '0; t.remain = '0;
               emit = 1'b1; res.kind = KIND_ERR;
            end else if (vdone) begin
               t.cnt = '0; t.due = t.due + {4'd0, acc}; t.acc = '0;
               t.phase = PH_STATUS; emit = 1'b1; res.kind = KIND_DUE;
               res.value = t.due;
            end
         end
         default: ;
      endcase
      if (fin_meta) begin
         t.phase = PH_DELTA;
         unique case (t.cnt)
            3'd0: p = 24'd0;
            3'd1: p = {t.payload[7:0], 16'd0};
            3'd2: p = {t.payload[15:0], 8'd0};
            default: p = t.payload;
         endcase
         t.cnt = '0; t.payload = p;
         if (t.mtype == META_TEMPO) begin
            need_div = 1'b1; res.kind = KIND_TICK;
         end else if (t.mtype == META_SEQ) begin
            emit = 1'b1; res.kind = KIND_SEQ; res.value = {16'd0, p[23:8]};
         end
      end
      wd = t;
   end

   assign tempo = (wd.payload == '0) ? 24'd1 : wd.payload;
   assign dividend = ((tpq_ff == 16'd0) ? 32'd1 : {16'd0, tpq_ff}) * {17'd0, TEMPO_SCALE};
   assign dstart = (st_ff == S_EXEC) && need_div;

   mtep_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dividend_ff),
      .divisor(tempo), .done(ddone), .quotient(dquot)
   );

   always_ff @(posedge clock) begin
      dividend_ff <= dividend;
      if (dstart) pend_ff <= res;
   end

   always_comb begin
      div_res = pend_ff;
      div_res.value = (dquot == '0) ? 32'd1 : dquot;
   end

   always_comb begin
      ts = rd_ff;
      if (rst_ff) ts = '0;
   end

   always_comb begin
      st_in = st_ff; we = 1'b0; wa = idx_ff;
      unique case (st_ff)
         S_CLR: begin
            we = 1'b1; wa = clr_ff;
            if (clr_ff == IW'(TRACK_COUNT - 1)) st_in = S_IDLE;
         end
         S_IDLE: if (req_valid && !ov_ff && {3'b0, req_track_id} < 7'(TRACK_COUNT))
            st_in = S_READ;
         S_READ: st_in = S_EXEC;
         S_EXEC: begin
            we = 1'b1; st_in = need_div ? S_DIV : S_IDLE;
         end
         S_DIV: if (ddone) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= (st_ff == S_CLR) ? '0 : wd;
      if (st_ff == S_READ) rd_ff <= mem[idx_ff];
      if (st_ff == S_IDLE) begin
         idx_ff <= IW'(req_track_id); tid_ff <= req_track_id;
         byte_ff <= req_data_byte; rst_ff <= req_restart;
      end
      if (reset) begin
         st_ff <= S_CLR; clr_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_CLR) clr_ff <= clr_ff + IW'(1);
         if (st_ff == S_EXEC && emit) begin
            ov_ff <= 1'b1; out_ff <= res;
         end else if (st_ff == S_DIV && ddone) begin
            ov_ff <= 1'b1; out_ff <= div_res;
         end else if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_out_track = out_ff.track;
   assign rsp_status_out = out_ff.status;
   assign rsp_first_data = out_ff.d1;
   assign rsp_second_data = out_ff.d2;
   assign rsp_value = out_ff.value;
   assign rsp_last = out_ff.last;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_div: assert property (@(posedge clock) disable iff (reset)
      ddone |-> (st_ff == S_DIV)) else $error("stray divider done");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> ov_ff) else $error("result dropped");
endmodule
`default_nettype wire

FILE: tb/tb_midi_track_event_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser
// Drives per-track MIDI byte streams (well-formed events plus noise), predicts
// every result with a behavioral parser model and checks the rsp words in order.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
   import mtep_pkg::*;

   class event_scoreboard;
      logic [3:0]  phase [16];
      logic [7:0]  rstat [16];
      logic [6:0]  held [16];
      logic [27:0] acc [16];
      logic [2:0]  cnt [16];
      logic [27:0] remain [16];
      logic [7:0]  mtype [16];
      logic [23:0] payload [16];
      logic [31:0] due [16];
      logic [15:0] tpq;
      rsp_type     pending [$];
      int          errors;

      function void clear_all();
         for (int t = 0; t < 16; t++) clear_track(t);
         tpq = 1;
         errors = 0;
      endfunction

      function void clear_track(int t);
         phase[t] = PH_DELTA; rstat[t] = 0; held[t] = 0; acc[t] = 0; cnt[t] = 0;
         remain[t] = 0; mtype[t] = 0; payload[t] = 0; due[t] = 0;
      endfunction

      function void push(logic [2:0] k, int t, logic [7:0] st, logic [6:0] a,
                         logic [6:0] b, logic [31:0] v, logic l);
         rsp_type r;
         r.kind = k; r.track = 4'(t); r.status = st; r.d1 = a; r.d2 = b;
         r.value = v; r.last = l;
         pending.push_back(r);
      endfunction

      function void fail_track(int t);
         phase[t] = PH_DELTA; acc[t] = 0; cnt[t] = 0; remain[t] = 0;
         push(KIND_ERR, t, 0, 0, 0, 0, 0);
      endfunction

      // 0 more, 1 done, 2 too long
      function int number_byte(int t, logic [7:0] b);
         acc[t] = {acc[t][20:0], b[6:0]};
         cnt[t] = cnt[t] + 3'd1;
         if (b[7]) return (cnt[t] >= 3'd4) ? 2 : 0;
         cnt[t] = 0;
         return 1;
      endfunction

      function void close_meta(int t);
         logic [23:0] p;
         logic [31:0] tempo, dv, stp;
         p = payload[t];
         if (cnt[t] < 3) p = p << (8 * (3 - cnt[t]));
         phase[t] = PH_DELTA; cnt[t] = 0; payload[t] = p;
         if (mtype[t] == META_TEMPO) begin
            tempo = (p == 0) ? 32'd1 : {8'd0, p};
            dv = (tpq == 0) ? 32'd1 : {16'd0, tpq};
            stp = (dv * 32'd25000) / tempo;
            if (stp == 0) stp = 1;
            push(KIND_TICK, t, 0, 0, 0, stp, 0);
         end else if (mtype[t] == META_SEQ)
            push(KIND_SEQ, t, 0, 0, 0, {16'd0, p[23:8]}, 0);
      endfunction

      function logic [3:0] after_status(logic [7:0] s, output bit bad);
         bad = 0;
         if (s < 8'h80) bad = 1;
         else if (s < 8'hF0) return PH_DATA1;
         else if (s <= 8'hF7) return PH_SYSLEN;
         else if (s == 8'hFF) return PH_METATYPE;
         else bad = 1;
         return PH_DELTA;
      endfunction

      function void parse(int t, logic [7:0] b);
         int r;
         bit bad;
         logic [3:0] nx;
         logic [1:0] dc;
         case (phase[t])
            PH_STATUS: begin
               if (b[7]) rstat[t] = b;
               nx = after_status(rstat[t], bad);
               if (bad) begin
                  fail_track(t);
                  return;
               end
               phase[t] = nx; acc[t] = 0; cnt[t] = 0;
               if (!b[7]) parse(t, b);
            end
            PH_DATA1: begin
               case (rstat[t][7:4])
                  4'hC, 4'hD: dc = 1;
                  default: dc = 2;
               endcase
               if (dc == 1) begin
                  phase[t] = PH_DELTA;
                  push(KIND_SHORT, t, rstat[t], b[6:0], 0, 0, 0);
               end else begin
                  held[t] = b[6:0];
                  phase[t] = PH_DATA2;
               end
            end
            PH_DATA2: begin
               phase[t] = PH_DELTA;
               push(KIND_SHORT, t, rstat[t], held[t], b[6:0], 0, 0);
            end
            PH_SYSLEN, PH_METALEN: begin
               r = number_byte(t, b);
               if (r == 2) fail_track(t);
               else if (r == 1) begin
                  remain[t] = acc[t]; acc[t] = 0;
                  if (phase[t] == PH_METALEN) begin
                     payload[t] = 0; cnt[t] = 0;
                     if (remain[t] == 0) close_meta(t);
                     else phase[t] = PH_METADATA;
                  end else
                     phase[t] = (remain[t] == 0) ? PH_DELTA : PH_SYSDATA;
               end
            end
            PH_SYSDATA: begin
               remain[t] = remain[t] - 28'd1;
               if (remain[t] == 0) begin
                  phase[t] = PH_DELTA;
                  push(KIND_SYSEX, t, 0, 0, 0, {24'd0, b}, 1);
               end else
                  push(KIND_SYSEX, t, 0, 0, 0, {24'd0, b}, 0);
            end
            PH_METATYPE: begin
               mtype[t] = b; acc[t] = 0; cnt[t] = 0; phase[t] = PH_METALEN;
            end
            PH_METADATA: begin
               if (cnt[t] < 3) begin
                  payload[t] = {payload[t][15:0], b};
                  cnt[t] = cnt[t] + 3'd1;
               end
               remain[t] = remain[t] - 28'd1;
               if (remain[t] == 0) close_meta(t);
            end
            default: begin
               phase[t] = PH_DELTA;
               r = number_byte(t, b);
               if (r == 2) fail_track(t);
               else if (r == 1) begin
                  due[t] = due[t] + {4'd0, acc[t]};
                  acc[t] = 0; phase[t] = PH_STATUS;
                  push(KIND_DUE, t, 0, 0, 0, due[t], 0);
               end
            end
         endcase
      endfunction

      function void note_byte(int t, logic [7:0] b, logic rs);
         if (rs) clear_track(t);
         parse(t, b);
      endfunction

      function void check_word(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected rsp word kind=%0d track=%0d", a.kind, a.track);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, a.kind); errors++; end
         if (a.track !== e.track) begin
            $error("out_track exp %0d got %0d", e.track, a.track); errors++; end
         if (a.status !== e.status) begin
            $error("status_out exp %h got %h", e.status, a.status); errors++; end
         if (a.d1 !== e.d1) begin
            $error("first_data exp %h got %h", e.d1, a.d1); errors++; end
         if (a.d2 !== e.d2) begin
            $error("second_data exp %h got %h", e.d2, a.d2); errors++; end
         if (a.value !== e.value) begin
            $error("value exp %h got %h", e.value, a.value); errors++; end
         if (a.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, a.last); errors++; end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_restart = 0;
   logic [3:0] req_track_id = 0;
   logic [7:0] req_data_byte = 0;
   logic rsp_stall = 0;
   logic req_stall, rsp_valid, rsp_last, pready;
   logic [2:0] rsp_kind;
   logic [3:0] rsp_out_track;
   logic [7:0] rsp_status_out;
   logic [6:0] rsp_first_data, rsp_second_data;
   logic [31:0] rsp_value, prdata;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0;

   event_scoreboard sb;
   bit quiet = 0;
   int idle_cycles = 0;
   int sent = 0;
   logic [7:0] last_status [16];

   always #1 clock = ~clock;

   midi_track_event_parser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_track_id(req_track_id), .req_data_byte(req_data_byte),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_out_track(rsp_out_track), .rsp_status_out(rsp_status_out),
      .rsp_first_data(rsp_first_data), .rsp_second_data(rsp_second_data),
      .rsp_value(rsp_value), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // result side: random stall, check accepted words
   always @(posedge clock) begin
      rsp_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            w.kind = rsp_kind; w.track = rsp_out_track; w.status = rsp_status_out;
            w.d1 = rsp_first_data; w.d2 = rsp_second_data; w.value = rsp_value;
            w.last = rsp_last;
            sb.check_word(w);
         end
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 25);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [15:0] v);
      psel <= 1; pwrite <= 1; paddr <= {CSR_TPQ, 2'b00}; pwdata <= {16'd0, v};
      penable <= 0;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.tpq = v;
   endtask

   task automatic send(int t, logic [7:0] b, logic rs = 0);
      while (!quiet && $urandom_range(0, 99) < 25) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_track_id <= 4'(t); req_data_byte <= b; req_restart <= rs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(t, b, rs);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_delta(int t);
      int n;
      n = $urandom_range(0, 9);
      if (n == 0) send(t, 8'(8'h80 | $urandom_range(0, 127)));
      if (n <= 1) send(t, 8'(8'h80 | $urandom_range(0, 127)));
      if (n <= 3) send(t, 8'(8'h80 | $urandom_range(0, 127)));
      send(t, 8'($urandom_range(0, 127)));
   endtask

   task automatic send_event(int t);
      int sel, len;
      logic [7:0] st;
      send_delta(t);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         st = 8'($urandom_range(8'h80, 8'hEF));
         if (last_status[t] >= 8'h80 && last_status[t] < 8'hF0 && sel < 15)
            st = last_status[t];
         else
            send(t, st);
         last_status[t] = st;
         send(t, 8'($urandom_range(0, 255)));
         if (st[7:4] != 4'hC && st[7:4] != 4'hD) send(t, 8'($urandom_range(0, 255)));
      end else if (sel < 60) begin
         send(t, 8'($urandom_range(8'hF0, 8'hF7)));
         last_status[t] = 8'hF0;
         len = $urandom_range(0, 6);
         send(t, 8'(len));
         repeat (len) send(t, 8'($urandom_range(0, 255)));
      end else if (sel < 85) begin
         send(t, 8'hFF);
         last_status[t] = 8'hFF;
         st = ($urandom_range(0, 2) == 0) ? META_SEQ :
              ($urandom_range(0, 3) == 0) ? 8'($urandom) : META_TEMPO;
         send(t, st);
         len = $urandom_range(0, 5);
         send(t, 8'(len));
         repeat (len) send(t, ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom));
      end else begin
         send(t, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      sb = new();
      sb.clear_all();
      for (int t = 0; t < 16; t++) last_status[t] = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: channel messages, running status, sysex, meta, errors
      send(0, 8'h00);
      send(0, 8'h90); send(0, 8'h3C); send(0, 8'hFF);
      send(0, 8'h81); send(0, 8'h00); send(0, 8'h40); send(0, 8'h7F);
      send(1, 8'hFF); send(1, 8'hFF); send(1, 8'h7F);
      send(1, 8'h00); send(1, 8'hC5); send(1, 8'h12);
      send(2, 8'h00); send(2, 8'h40);
      send(3, 8'h05); send(3, 8'hF0); send(3, 8'h02); send(3, 8'hAA); send(3, 8'h55);
      send(4, 8'h00); send(4, 8'hFF); send(4, 8'h51); send(4, 8'h00);
      send(5, 8'h00); send(5, 8'hF8);
      send(6, 8'h00); send(6, 8'hFF); send(6, 8'h00); send(6, 8'h02);
      send(6, 8'h12); send(6, 8'h34);
      send(7, 8'h00, 1);
      drain();

      // long run with no idling
      quiet = 1;
      for (int i = 0; i < 60; i++) send_event($urandom_range(0, 15));
      quiet = 0;
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: csr_write(16'hFFFF);
            1: csr_write(16'd0);
            2: csr_write(16'd96);
            default: csr_write(16'($urandom_range(1, 65535)));
         endcase
         while (sent < 250 * (ph + 1) + 200) begin
            if ($urandom_range(0, 9) == 0) send($urandom_range(0, 15), 8'($urandom),
                                               1'($urandom_range(0, 1)));
            else send_event($urandom_range(0, 15));
         end
         drain();
      end

      if (sb.pending.size() != 0) begin
         $error("%0d expected words never arrived", sb.pending.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

FILE: filelist.f
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_divider.sv
hw/rtl/midi_track_event_parser.sv
tb/tb_midi_track_event_parser.sv
